>>> rtl/core/cbm_pkg.sv
// shared types, codes and constants for the cartridge bank mapper
package cbm_pkg;

    localparam int PATTERN_SLOTS           = 8;
    localparam int SLOT_BITS               = $clog2(PATTERN_SLOTS);
    localparam int PRESCALE_PERIOD_DEFAULT = 114;

    localparam int ADDR_W   = 16;
    localparam int DATA_W   = 8;
    localparam int CYCLES_W = 10;
    localparam int PROG_W   = 8;
    localparam int PAT_W    = 12;
    localparam int MIRROR_W = 2;
    localparam int COUNT_W  = 9;
    localparam int ACC_W    = 9;
    localparam int IRQ_W    = 8;

    typedef enum logic [1:0] {
        CMD_WRITE   = 2'd0,
        CMD_TICK    = 2'd1,
        CMD_PATTERN = 2'd2,
        CMD_PROGRAM = 2'd3
    } cmd_t;

    localparam logic [15:0] ADDR_PROG0    = 16'h8010;
    localparam logic [15:0] ADDR_PROG1    = 16'hA010;
    localparam logic [15:0] ADDR_MIRROR   = 16'h9400;
    localparam logic [15:0] DEC_MASK      = 16'hF00C;
    localparam logic [15:0] DEC_RELOAD_LO = 16'hF000;
    localparam logic [15:0] DEC_RELOAD_HI = 16'hF004;
    localparam logic [15:0] DEC_IRQ_MODE  = 16'hF008;
    localparam logic [3:0]  PAT_HI_FIRST  = 4'hB;
    localparam logic [3:0]  PAT_HI_LAST   = 4'hE;

    localparam logic [PAT_W-1:0] PAT_KEEP_A = 12'h088;
    localparam logic [PAT_W-1:0] PAT_KEEP_B = 12'h0C8;
    localparam logic [PAT_W-1:0] PAT_VRAM_A = 12'h004;
    localparam logic [PAT_W-1:0] PAT_VRAM_B = 12'h005;

    localparam logic [IRQ_W-1:0]   COUNT_TOP = 8'hFF;
    localparam logic [ACC_W:0]     ACC_SAT   = 10'd511;
    localparam logic [COUNT_W-1:0] BANKS_MIN = 9'd2;
    localparam logic [COUNT_W-1:0] BANKS_MAX = 9'd256;
    localparam logic [COUNT_W-1:0] BANKS_RESET = 9'd32;

    // cycles / 3 as (cycles * 683) >> 11, exact below 1024
    localparam logic [19:0] DIV3_MUL   = 20'd683;
    localparam int          DIV3_SHIFT = 11;

    typedef struct packed {
        cmd_t                command;
        logic [ADDR_W-1:0]   address;
        logic [DATA_W-1:0]   write_data;
        logic [CYCLES_W-1:0] tick_cycles;
    } item_t;

    typedef struct packed {
        logic [PROG_W-1:0]   program_bank;
        logic [PAT_W-1:0]    pattern_bank;
        logic                pattern_from_vram;
        logic [MIRROR_W-1:0] mirroring;
    } lookup_t;

    typedef struct packed {
        logic                irq_fire;
        logic [PROG_W-1:0]   program_bank;
        logic [PAT_W-1:0]    pattern_bank;
        logic                pattern_from_vram;
        logic [MIRROR_W-1:0] mirroring;
    } result_t;

endpackage

>>> rtl/core/cbm_if.sv
// valid/ready channel interfaces for items, results and configuration
interface cbm_in_if;
    logic                          valid;
    logic                          ready;
    logic [1:0]                    command;
    logic [cbm_pkg::ADDR_W-1:0]    address;
    logic [cbm_pkg::DATA_W-1:0]    write_data;
    logic [cbm_pkg::CYCLES_W-1:0]  tick_cycles;

    modport source (output valid, command, address, write_data, tick_cycles, input ready);
    modport sink (input valid, command, address, write_data, tick_cycles, output ready);
endinterface

interface cbm_out_if;
    logic                          valid;
    logic                          ready;
    logic                          irq_fire;
    logic [cbm_pkg::PROG_W-1:0]    program_bank;
    logic [cbm_pkg::PAT_W-1:0]     pattern_bank;
    logic                          pattern_from_vram;
    logic [cbm_pkg::MIRROR_W-1:0]  mirroring;

    modport source (output valid, irq_fire, program_bank, pattern_bank, pattern_from_vram,
                    mirroring, input ready);
    modport sink (input valid, irq_fire, program_bank, pattern_bank, pattern_from_vram,
                  mirroring, output ready);
endinterface

interface cbm_cfg_if;
    logic                          valid;
    logic                          ready;
    logic [cbm_pkg::COUNT_W-1:0]   program_bank_count;

    modport source (output valid, program_bank_count, input ready);
    modport sink (input valid, program_bank_count, output ready);
endinterface

>>> rtl/core/cbm_bank_regs.sv
// program, mirroring and pattern bank registers with lookup logic
module cbm_bank_regs (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          step,
    input  cbm_pkg::item_t                item,
    input  logic                          cfg_we,
    input  logic [cbm_pkg::COUNT_W-1:0]   cfg_data,
    output cbm_pkg::lookup_t              lookup
);
    import cbm_pkg::*;

    logic [COUNT_W-1:0]  bank_count_reg;
    logic [PROG_W-1:0]   prog0_reg;
    logic [PROG_W-1:0]   prog1_reg;
    logic [MIRROR_W-1:0] mirror_reg;
    logic [MIRROR_W-1:0] mirror_next;

    logic [PAT_W-1:0] pat_reg  [PATTERN_SLOTS];
    logic [PAT_W-1:0] map_reg  [PATTERN_SLOTS];
    logic             vram_reg [PATTERN_SLOTS];

    logic              wr;
    logic [ADDR_W-1:0] dec;
    logic [3:0]        dec_hi;
    logic [3:0]        wsub;
    logic [SLOT_BITS-1:0] wslot;
    logic              pat_hit;

    logic [SLOT_BITS-1:0] rslot;
    logic [COUNT_W-1:0]   n_clamp;
    logic [COUNT_W-1:0]   n_minus2;
    logic [COUNT_W-1:0]   n_minus1;
    logic [PROG_W-1:0]    prog_sel;

    assign wr      = step && (item.command == CMD_WRITE) && item.address[15];
    assign dec     = item.address & DEC_MASK;
    assign dec_hi  = dec[15:12];
    assign wsub    = dec_hi - PAT_HI_FIRST;
    assign wslot   = {wsub[1:0], item.address[3]};
    assign pat_hit = wr && (dec_hi >= PAT_HI_FIRST) && (dec_hi <= PAT_HI_LAST);

    always_comb
    begin
        mirror_next = mirror_reg;
        if (wr && (item.address == ADDR_MIRROR))
        begin
            mirror_next = item.write_data[MIRROR_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bank_count_reg <= BANKS_RESET;
            prog0_reg      <= '0;
            prog1_reg      <= '0;
            mirror_reg     <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                bank_count_reg <= cfg_data;
            end
            if (wr && (item.address == ADDR_PROG0))
            begin
                prog0_reg <= item.write_data;
            end
            if (wr && (item.address == ADDR_PROG1))
            begin
                prog1_reg <= item.write_data;
            end
            mirror_reg <= mirror_next;
        end
    end

    for (genvar s = 0; s < PATTERN_SLOTS; s++)
    begin : g_slot
        logic [PAT_W-1:0] pat_next;
        logic             hit;

        assign hit = pat_hit && (wslot == SLOT_BITS'(s));

        always_comb
        begin
            if (item.address[2])
            begin
                pat_next = {item.write_data, pat_reg[s][3:0]};
            end
            else
            begin
                pat_next = {pat_reg[s][PAT_W-1:4], item.write_data[3:0]};
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                pat_reg[s]  <= PAT_W'(s);
                map_reg[s]  <= PAT_W'(s);
                vram_reg[s] <= (PAT_W'(s) == PAT_VRAM_A) || (PAT_W'(s) == PAT_VRAM_B);
            end
            else if (hit)
            begin
                pat_reg[s] <= pat_next;
                // two special values leave the slot's mapping alone
                if ((pat_next != PAT_KEEP_A) && (pat_next != PAT_KEEP_B))
                begin
                    map_reg[s]  <= pat_next;
                    vram_reg[s] <= (pat_next == PAT_VRAM_A) || (pat_next == PAT_VRAM_B);
                end
            end
        end
    end

    assign rslot = item.address[10 +: SLOT_BITS];

    always_comb
    begin
        n_clamp = bank_count_reg;
        if (bank_count_reg < BANKS_MIN)
        begin
            n_clamp = BANKS_MIN;
        end
        else if (bank_count_reg > BANKS_MAX)
        begin
            n_clamp = BANKS_MAX;
        end
    end

    assign n_minus2 = n_clamp - COUNT_W'(2);
    assign n_minus1 = n_clamp - COUNT_W'(1);

    always_comb
    begin
        case (item.address[14:13])
            2'd0:    prog_sel = prog0_reg;
            2'd1:    prog_sel = prog1_reg;
            2'd2:    prog_sel = n_minus2[PROG_W-1:0];
            default: prog_sel = n_minus1[PROG_W-1:0];
        endcase
    end

    always_comb
    begin
        lookup.program_bank      = '0;
        lookup.pattern_bank      = '0;
        lookup.pattern_from_vram = 1'b0;
        lookup.mirroring         = mirror_next;
        case (item.command)
            CMD_PATTERN:
            begin
                lookup.pattern_bank      = map_reg[rslot];
                lookup.pattern_from_vram = vram_reg[rslot];
            end
            CMD_PROGRAM:
            begin
                lookup.program_bank = prog_sel;
            end
            default:
            begin
                lookup.program_bank = '0;
            end
        endcase
    end

endmodule

>>> rtl/core/cbm_irq.sv
// scanline irq: reload latch, mode, prescaler and 8-bit counter
module cbm_irq #(
    parameter int PRESCALE_PERIOD = cbm_pkg::PRESCALE_PERIOD_DEFAULT
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           step,
    input  cbm_pkg::item_t item,
    output logic           fire
);
    import cbm_pkg::*;

    localparam logic [ACC_W-1:0] PERIOD = ACC_W'(PRESCALE_PERIOD);

    logic [IRQ_W-1:0] reload_reg;
    logic [IRQ_W-1:0] reload_next;
    logic [1:0]       mode_reg;
    logic [1:0]       mode_next;
    logic [IRQ_W-1:0] count_reg;
    logic [IRQ_W-1:0] count_next;
    logic [ACC_W-1:0] acc_reg;
    logic [ACC_W-1:0] acc_next;

    logic              wr;
    logic [ADDR_W-1:0] dec;
    logic [19:0]       prod;
    logic [ACC_W-1:0]  steps;
    logic [ACC_W:0]    sum;
    logic [ACC_W-1:0]  sat;

    assign wr    = step && (item.command == CMD_WRITE) && item.address[15];
    assign dec   = item.address & DEC_MASK;
    assign prod  = {10'd0, item.tick_cycles} * DIV3_MUL;
    assign steps = prod[DIV3_SHIFT +: ACC_W];
    assign sum   = {1'b0, acc_reg} + {1'b0, steps};
    assign sat   = (sum > ACC_SAT) ? ACC_SAT[ACC_W-1:0] : sum[ACC_W-1:0];

    always_comb
    begin
        reload_next = reload_reg;
        mode_next   = mode_reg;
        count_next  = count_reg;
        acc_next    = acc_reg;
        fire        = 1'b0;
        if (wr && (dec == DEC_RELOAD_LO))
        begin
            reload_next = {reload_reg[7:4], item.write_data[3:0]};
        end
        else if (wr && (dec == DEC_RELOAD_HI))
        begin
            reload_next = {item.write_data[3:0], reload_reg[3:0]};
        end
        else if (wr && (dec == DEC_IRQ_MODE))
        begin
            mode_next = item.write_data[1:0];
            if (item.write_data[1])
            begin
                count_next = reload_reg;
                acc_next   = '0;
            end
        end
        else if (step && (item.command == CMD_TICK) && mode_reg[1])
        begin
            if (sat >= PERIOD)
            begin
                acc_next = sat - PERIOD;
                if (count_reg == COUNT_TOP)
                begin
                    count_next = reload_reg;
                    mode_next  = mode_reg[0] ? 2'b11 : 2'b00;
                    fire       = 1'b1;
                end
                else
                begin
                    count_next = count_reg + IRQ_W'(1);
                end
            end
            else
            begin
                acc_next = sat;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            reload_reg <= '0;
            mode_reg   <= '0;
            count_reg  <= '0;
            acc_reg    <= '0;
        end
        else
        begin
            reload_reg <= reload_next;
            mode_reg   <= mode_next;
            count_reg  <= count_next;
            acc_reg    <= acc_next;
        end
    end

    a_fire_needs_enabled_tick: assert property (@(posedge clk) disable iff (!rst_n)
        fire |-> (step && (item.command == CMD_TICK) && mode_reg[1]))
        else $error("irq fired outside an enabled tick");

    a_fire_reloads: assert property (@(posedge clk) disable iff (!rst_n)
        fire |=> (count_reg == $past(reload_reg)) && (mode_reg[1] == $past(mode_reg[0])))
        else $error("irq fire did not reload counter and mode");

    a_lookup_keeps_irq: assert property (@(posedge clk) disable iff (!rst_n)
        (!step || (item.command == CMD_PATTERN) || (item.command == CMD_PROGRAM))
        |=> $stable(count_reg) && $stable(mode_reg) && $stable(acc_reg))
        else $error("irq state changed without a write or tick");

endmodule

>>> rtl/core/cartridge_bank_mapper_with_irq.sv
// top level of the cartridge bank mapper with scanline irq
//
// channel  dir  handshake      word
// item     in   valid/ready    command, address, write_data, tick_cycles
// result   out  valid/ready    irq_fire, program_bank, pattern_bank, pattern_from_vram, mirroring
// cfg      in   valid/ready    program_bank_count (ready always high)
//
// one word per cycle sustained while results are taken; a word waits in the input register
// and its result is registered when the word advances out of it
// state is updated in the cycle the word moves into the result register
// all mapper and irq state and the valid flags take their reset values at once; no clearing pass
// a held result stalls the input register, which still takes one more word
module cartridge_bank_mapper_with_irq #(
    parameter int PRESCALE_PERIOD = cbm_pkg::PRESCALE_PERIOD_DEFAULT
) (
    input  logic      clk,
    input  logic      rst_n,
    cbm_in_if.sink    item,
    cbm_out_if.source result,
    cbm_cfg_if.sink   cfg
);
    import cbm_pkg::*;

    item_t   item_reg;
    logic    item_valid_reg;
    result_t res_reg;
    result_t res_next;
    logic    res_valid_reg;
    logic    advance;
    logic    accept;
    logic    fire;
    lookup_t lookup;

    assign advance    = item_valid_reg && (!res_valid_reg || result.ready);
    assign item.ready = !item_valid_reg || advance;
    assign accept     = item.valid && item.ready;
    assign cfg.ready  = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_valid_reg <= 1'b0;
            res_valid_reg  <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                item_valid_reg <= 1'b1;
            end
            else if (advance)
            begin
                item_valid_reg <= 1'b0;
            end
            if (advance)
            begin
                res_valid_reg <= 1'b1;
            end
            else if (result.ready)
            begin
                res_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            item_reg.command     <= cmd_t'(item.command);
            item_reg.address     <= item.address;
            item_reg.write_data  <= item.write_data;
            item_reg.tick_cycles <= item.tick_cycles;
        end
        if (advance)
        begin
            res_reg <= res_next;
        end
    end

    cbm_bank_regs u_bank_regs (
        .clk      (clk),
        .rst_n    (rst_n),
        .step     (advance),
        .item     (item_reg),
        .cfg_we   (cfg.valid),
        .cfg_data (cfg.program_bank_count),
        .lookup   (lookup)
    );

    cbm_irq #(
        .PRESCALE_PERIOD (PRESCALE_PERIOD)
    ) u_irq (
        .clk   (clk),
        .rst_n (rst_n),
        .step  (advance),
        .item  (item_reg),
        .fire  (fire)
    );

    always_comb
    begin
        res_next.irq_fire          = fire;
        res_next.program_bank      = lookup.program_bank;
        res_next.pattern_bank      = lookup.pattern_bank;
        res_next.pattern_from_vram = lookup.pattern_from_vram;
        res_next.mirroring         = lookup.mirroring;
    end

    assign result.valid             = res_valid_reg;
    assign result.irq_fire          = res_reg.irq_fire;
    assign result.program_bank      = res_reg.program_bank;
    assign result.pattern_bank      = res_reg.pattern_bank;
    assign result.pattern_from_vram = res_reg.pattern_from_vram;
    assign result.mirroring         = res_reg.mirroring;

endmodule

>>> verif/tb_cartridge_bank_mapper_with_irq.sv
// testbench for the cartridge bank mapper: directed and random words checked by a scoreboard
`timescale 1ns / 1ps

module tb_cartridge_bank_mapper_with_irq;

    import cbm_pkg::*;

    localparam int PERIOD          = PRESCALE_PERIOD_DEFAULT;
    localparam int STALL_LIMIT     = 5000;
    localparam int WORDS_PER_PHASE = 106;
    localparam int PHASES          = 8;

    class bank_map_scoreboard;
        logic [PROG_W-1:0]   prog_regs [2];
        logic [MIRROR_W-1:0] mirror_mode;
        logic [PAT_W-1:0]    pat_regs [PATTERN_SLOTS];
        logic [PAT_W:0]      pat_map [PATTERN_SLOTS];
        logic [IRQ_W-1:0]    irq_reload;
        logic [IRQ_W-1:0]    irq_count;
        logic [1:0]          irq_mode;
        logic [ACC_W-1:0]    prescale;
        logic [COUNT_W-1:0]  bank_count;
        result_t             expected_results [$];
        int                  errors;

        function new();
            prog_regs[0] = '0;
            prog_regs[1] = '0;
            mirror_mode  = '0;
            for (int s = 0; s < PATTERN_SLOTS; s++)
            begin
                pat_regs[s] = PAT_W'(s);
                pat_map[s]  = (PAT_W + 1)'(s);
            end
            remap_patterns();
            irq_reload = '0;
            irq_count  = '0;
            irq_mode   = '0;
            prescale   = '0;
            bank_count = BANKS_RESET;
            errors     = 0;
        endfunction

        function void remap_patterns();
            logic [PAT_W-1:0] v;
            for (int s = 0; s < PATTERN_SLOTS; s++)
            begin
                v = pat_regs[s];
                if (v == PAT_KEEP_A || v == PAT_KEEP_B)
                    continue;
                pat_map[s] = {(v == PAT_VRAM_A || v == PAT_VRAM_B), v};
            end
        endfunction

        function void report(string msg);
            errors++;
            if (errors <= 40)
                $display("%0t ERROR %s", $time, msg);
        endfunction

        function int pending();
            return expected_results.size();
        endfunction

        function result_t predict_mapping(item_t w);
            result_t          r;
            logic [15:0]      dec;
            logic [3:0]       bank_hi;
            logic [2:0]       slot;
            logic [10:0]      acc;
            logic [COUNT_W-1:0] n;
            logic [PAT_W:0]   m;
            r = '0;
            case (w.command)
                CMD_WRITE:
                    if (w.address[15])
                    begin
                        if (w.address == ADDR_PROG0)
                            prog_regs[0] = w.write_data;
                        else if (w.address == ADDR_PROG1)
                            prog_regs[1] = w.write_data;
                        else if (w.address == ADDR_MIRROR)
                            mirror_mode = w.write_data[1:0];
                        dec = w.address & DEC_MASK;
                        if (dec[15:12] >= PAT_HI_FIRST && dec[15:12] <= PAT_HI_LAST)
                        begin
                            bank_hi = dec[15:12] - PAT_HI_FIRST;
                            slot = {bank_hi[1:0], dec[3]};
                            if (dec[2])
                                pat_regs[slot] = {w.write_data, pat_regs[slot][3:0]};
                            else
                                pat_regs[slot][3:0] = w.write_data[3:0];
                        end
                        else if (dec == DEC_RELOAD_LO)
                            irq_reload[3:0] = w.write_data[3:0];
                        else if (dec == DEC_RELOAD_HI)
                            irq_reload[7:4] = w.write_data[3:0];
                        else if (dec == DEC_IRQ_MODE)
                        begin
                            irq_mode = w.write_data[1:0];
                            if (irq_mode[1])
                            begin
                                irq_count = irq_reload;
                                prescale  = '0;
                            end
                        end
                        remap_patterns();
                    end
                CMD_TICK:
                    if (irq_mode[1])
                    begin
                        acc = 11'(prescale) + 11'(w.tick_cycles / 3);
                        if (acc > 11'(ACC_SAT))
                            acc = 11'(ACC_SAT);
                        if (acc >= 11'(PERIOD))
                        begin
                            acc = acc - 11'(PERIOD);
                            if (irq_count == COUNT_TOP)
                            begin
                                irq_count  = irq_reload;
                                irq_mode   = {2{irq_mode[0]}};
                                r.irq_fire = 1'b1;
                            end
                            else
                                irq_count = irq_count + 1'b1;
                        end
                        prescale = acc[ACC_W-1:0];
                    end
                CMD_PATTERN:
                begin
                    m = pat_map[w.address[12:10]];
                    r.pattern_bank      = m[PAT_W-1:0];
                    r.pattern_from_vram = m[PAT_W];
                end
                default:
                begin
                    n = bank_count;
                    if (n < BANKS_MIN)
                        n = BANKS_MIN;
                    if (n > BANKS_MAX)
                        n = BANKS_MAX;
                    case (w.address[14:13])
                        2'd0: r.program_bank = prog_regs[0];
                        2'd1: r.program_bank = prog_regs[1];
                        2'd2: r.program_bank = PROG_W'(n - 9'd2);
                        default: r.program_bank = PROG_W'(n - 9'd1);
                    endcase
                end
            endcase
            r.mirroring = mirror_mode;
            return r;
        endfunction

        function void note_item(item_t w);
            expected_results.push_back(predict_mapping(w));
        endfunction

        function void check_result(result_t got);
            result_t want;
            if (expected_results.size() == 0)
            begin
                report($sformatf("result word with nothing expected: %h", got));
                return;
            end
            want = expected_results.pop_front();
            if (got.irq_fire !== want.irq_fire)
                report($sformatf("irq_fire got %0h expected %0h", got.irq_fire, want.irq_fire));
            if (got.program_bank !== want.program_bank)
                report($sformatf("program_bank got %0h expected %0h",
                                 got.program_bank, want.program_bank));
            if (got.pattern_bank !== want.pattern_bank)
                report($sformatf("pattern_bank got %0h expected %0h",
                                 got.pattern_bank, want.pattern_bank));
            if (got.pattern_from_vram !== want.pattern_from_vram)
                report($sformatf("pattern_from_vram got %0h expected %0h",
                                 got.pattern_from_vram, want.pattern_from_vram));
            if (got.mirroring !== want.mirroring)
                report($sformatf("mirroring got %0h expected %0h", got.mirroring, want.mirroring));
        endfunction
    endclass

    logic clk = 1'b0;
    logic rst_n;
    bit   no_idle = 1'b0;
    int   quiet_cycles = 0;

    logic [COUNT_W-1:0] bank_settings [6] = '{9'd2, 9'd256, 9'd0, 9'd511, 9'd1, 9'd257};

    bank_map_scoreboard sb;

    cbm_in_if  item_ch();
    cbm_out_if result_ch();
    cbm_cfg_if cfg_ch();

    cartridge_bank_mapper_with_irq #(
        .PRESCALE_PERIOD(PERIOD)
    ) u_dut (
        .clk(clk),
        .rst_n(rst_n),
        .item(item_ch),
        .result(result_ch),
        .cfg(cfg_ch)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    function automatic int idle_cycles();
        int r;
        r = $urandom_range(0, 99);
        if (no_idle || r < 55)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic logic [15:0] random_write_address();
        logic [15:0] a;
        a = 16'($urandom);
        case ($urandom_range(0, 9))
            0: a = ADDR_PROG0;
            1: a = ADDR_PROG1;
            2: a = ADDR_MIRROR;
            3, 4, 5: a[15:12] = PAT_HI_FIRST + 4'($urandom_range(0, 3));
            6, 7: a[15:12] = DEC_RELOAD_LO[15:12];
            8: a[15] = 1'b0;
            default: ;
        endcase
        return a;
    endfunction

    function automatic logic [7:0] random_write_data(logic [15:0] a);
        logic [7:0]  d;
        logic [15:0] dec;
        d = 8'($urandom);
        dec = a & DEC_MASK;
        if ($urandom_range(0, 3) == 0)
            return d;
        if (dec == DEC_RELOAD_HI)
            d[3:0] = 4'hF;
        else if (dec == DEC_IRQ_MODE)
            d[1] = 1'b1;
        else if (dec[15:12] >= PAT_HI_FIRST && dec[15:12] <= PAT_HI_LAST)
        begin
            if (dec[2])
                case ($urandom_range(0, 3))
                    0: d = PAT_KEEP_A[11:4];
                    1: d = PAT_KEEP_B[11:4];
                    2: d = PAT_VRAM_A[11:4];
                    default: ;
                endcase
            else
                case ($urandom_range(0, 3))
                    0: d[3:0] = PAT_KEEP_A[3:0];
                    1: d[3:0] = PAT_VRAM_A[3:0];
                    2: d[3:0] = PAT_VRAM_B[3:0];
                    default: ;
                endcase
        end
        return d;
    endfunction

    function automatic item_t random_word();
        item_t w;
        int    pick;
        w.address     = 16'($urandom);
        w.write_data  = 8'($urandom);
        w.tick_cycles = 10'($urandom);
        pick = $urandom_range(0, 99);
        if (pick < 40)
        begin
            w.command    = CMD_WRITE;
            w.address    = random_write_address();
            w.write_data = random_write_data(w.address);
        end
        else if (pick < 65)
        begin
            w.command = CMD_TICK;
            if ($urandom_range(0, 4) < 3)
                w.tick_cycles = 10'($urandom_range(330, 345));
        end
        else if (pick < 85)
            w.command = CMD_PATTERN;
        else
            w.command = CMD_PROGRAM;
        return w;
    endfunction

    task automatic drive_word(item_t w);
        int gap;
        gap = idle_cycles();
        if (gap > 0)
        begin
            item_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        item_ch.valid       <= 1'b1;
        item_ch.command     <= w.command;
        item_ch.address     <= w.address;
        item_ch.write_data  <= w.write_data;
        item_ch.tick_cycles <= w.tick_cycles;
        do
            @(posedge clk);
        while (!item_ch.ready);
        sb.note_item(w);
    endtask

    task automatic send(cmd_t c, logic [15:0] a, logic [7:0] d, logic [9:0] cyc);
        item_t w;
        w.command     = c;
        w.address     = a;
        w.write_data  = d;
        w.tick_cycles = cyc;
        drive_word(w);
    endtask

    task automatic run_directed();
        send(CMD_PROGRAM, 16'h0000, 8'h00, 10'd0);
        send(CMD_PROGRAM, 16'hE000, 8'h00, 10'd0);
        send(CMD_PROGRAM, 16'h4000, 8'h00, 10'd0);
        send(CMD_WRITE,   ADDR_PROG0, 8'hFF, 10'd0);
        send(CMD_WRITE,   ADDR_PROG1, 8'h80, 10'd0);
        send(CMD_PROGRAM, 16'hA000, 8'h00, 10'd0);
        send(CMD_PROGRAM, 16'h1FFF, 8'h00, 10'd0);
        send(CMD_WRITE,   ADDR_MIRROR, 8'h03, 10'd0);
        send(CMD_WRITE,   16'h7FFF, 8'hFF, 10'd1023);
        send(CMD_PATTERN, 16'h1000, 8'h00, 10'd0);
        send(CMD_WRITE,   16'hB000, 8'h08, 10'd0);
        send(CMD_WRITE,   16'hB004, 8'h08, 10'd0);
        send(CMD_PATTERN, 16'h0000, 8'h00, 10'd0);
        send(CMD_WRITE,   16'hE00C, 8'hFF, 10'd0);
        send(CMD_PATTERN, 16'hFC00, 8'h00, 10'd0);
        send(CMD_WRITE,   DEC_RELOAD_LO, 8'h0E, 10'd0);
        send(CMD_WRITE,   DEC_RELOAD_HI, 8'h0F, 10'd0);
        send(CMD_TICK,    16'h0000, 8'h00, 10'd1023);
        send(CMD_WRITE,   DEC_IRQ_MODE, 8'h03, 10'd0);
        send(CMD_TICK,    16'h0000, 8'h00, 10'd1023);
        send(CMD_TICK,    16'h0000, 8'h00, 10'd1023);
        send(CMD_TICK,    16'h0000, 8'h00, 10'd0);
        send(CMD_TICK,    16'h0000, 8'h00, 10'd0);
        send(CMD_WRITE,   ADDR_MIRROR, 8'hFE, 10'd0);
        send(CMD_WRITE,   16'hC008, 8'h0C, 10'd0);
    endtask

    initial
    begin
        result_ch.ready = 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            result_ch.ready <= 1'b1;
            repeat ($urandom_range(1, 12)) @(posedge clk);
            if (idle_cycles() > 0)
            begin
                result_ch.ready <= 1'b0;
                repeat (idle_cycles() + 1) @(posedge clk);
            end
        end
    end

    always @(posedge clk)
    begin
        result_t seen;
        seen.irq_fire          = result_ch.irq_fire;
        seen.program_bank      = result_ch.program_bank;
        seen.pattern_bank      = result_ch.pattern_bank;
        seen.pattern_from_vram = result_ch.pattern_from_vram;
        seen.mirroring         = result_ch.mirroring;
        if (rst_n === 1'b1 && result_ch.valid && result_ch.ready)
            sb.check_result(seen);
    end

    always @(posedge clk)
    begin
        if (!rst_n || (item_ch.valid && item_ch.ready) || (result_ch.valid && result_ch.ready)
            || (cfg_ch.valid && cfg_ch.ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("cartridge_bank_mapper_with_irq verification failed");
            $finish;
        end
    end

    initial
    begin
        logic [COUNT_W-1:0] banks;
        sb = new();
        item_ch.valid               = 1'b0;
        item_ch.command             = CMD_WRITE;
        item_ch.address             = '0;
        item_ch.write_data          = '0;
        item_ch.tick_cycles         = '0;
        cfg_ch.valid                = 1'b0;
        cfg_ch.program_bank_count   = BANKS_RESET;
        rst_n = 1'b0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        run_directed();
        for (int p = 0; p < PHASES; p++)
        begin
            if (p > 0)
            begin
                // bank count changes only with the pipeline drained
                item_ch.valid <= 1'b0;
                while (sb.pending() != 0) @(posedge clk);
                repeat (4) @(posedge clk);
                banks = (p <= 6) ? bank_settings[p - 1] : COUNT_W'($urandom_range(2, 256));
                cfg_ch.valid              <= 1'b1;
                cfg_ch.program_bank_count <= banks;
                do
                    @(posedge clk);
                while (!cfg_ch.ready);
                cfg_ch.valid <= 1'b0;
                sb.bank_count = banks;
            end
            no_idle = (p % 3 == 2);
            repeat (WORDS_PER_PHASE) drive_word(random_word());
        end
        item_ch.valid <= 1'b0;
        while (sb.pending() != 0) @(posedge clk);
        repeat (8) @(posedge clk);
        if (sb.errors == 0)
            $display("cartridge_bank_mapper_with_irq verification clean");
        else
            $display("cartridge_bank_mapper_with_irq verification failed");
        $finish;
    end

endmodule
